/* rtl/apr_pkg.sv */
package apr_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_RESOLVE = 2'd2
    } op_t;

    // Multiplier operand A sources.
    typedef enum logic [2:0] {
        SA_AX, SA_AY, SA_AZ, SA_AW, SA_VX, SA_VY, SA_VZ
    } srca_t;

    // Multiplier operand B sources.
    typedef enum logic [4:0] {
        SB_BX, SB_BY, SB_BZ, SB_BW,
        SB_AX, SB_AY, SB_AZ, SB_AW,
        SB_M00, SB_M01, SB_M02, SB_M10, SB_M11, SB_M12, SB_M20, SB_M21, SB_M22
    } srcb_t;

    // Result registers written at the end of an accumulation group.
    typedef enum logic [3:0] {
        D_QX, D_QY, D_QZ, D_QW,
        D_M00, D_M01, D_M02, D_M10, D_M11, D_M12, D_M20, D_M21, D_M22,
        D_PX, D_PY, D_PZ
    } dest_t;

    // One multiply-accumulate micro-operation.
    typedef struct packed {
        srca_t a;
        srcb_t b;
        logic  neg;
        logic  dbl;
        logic  first;
        logic  last;
        dest_t dst;
    } uop_t;

    localparam int NUM_UOPS = 49;
    localparam int STEP_END = NUM_UOPS + 1;

    typedef logic [5:0] step_t;

    // Micro-program: quaternion product, rotation matrix, rotated offset.
    localparam uop_t UCODE [NUM_UOPS] = '{
        '{SA_AW, SB_BX, 1'b0, 1'b0, 1'b1, 1'b0, D_QX},
        '{SA_AX, SB_BW, 1'b0, 1'b0, 1'b0, 1'b0, D_QX},
        '{SA_AY, SB_BZ, 1'b0, 1'b0, 1'b0, 1'b0, D_QX},
        '{SA_AZ, SB_BY, 1'b1, 1'b0, 1'b0, 1'b1, D_QX},
        '{SA_AW, SB_BY, 1'b0, 1'b0, 1'b1, 1'b0, D_QY},
        '{SA_AX, SB_BZ, 1'b1, 1'b0, 1'b0, 1'b0, D_QY},
        '{SA_AY, SB_BW, 1'b0, 1'b0, 1'b0, 1'b0, D_QY},
        '{SA_AZ, SB_BX, 1'b0, 1'b0, 1'b0, 1'b1, D_QY},
        '{SA_AW, SB_BZ, 1'b0, 1'b0, 1'b1, 1'b0, D_QZ},
        '{SA_AX, SB_BY, 1'b0, 1'b0, 1'b0, 1'b0, D_QZ},
        '{SA_AY, SB_BX, 1'b1, 1'b0, 1'b0, 1'b0, D_QZ},
        '{SA_AZ, SB_BW, 1'b0, 1'b0, 1'b0, 1'b1, D_QZ},
        '{SA_AW, SB_BW, 1'b0, 1'b0, 1'b1, 1'b0, D_QW},
        '{SA_AX, SB_BX, 1'b1, 1'b0, 1'b0, 1'b0, D_QW},
        '{SA_AY, SB_BY, 1'b1, 1'b0, 1'b0, 1'b0, D_QW},
        '{SA_AZ, SB_BZ, 1'b1, 1'b0, 1'b0, 1'b1, D_QW},
        '{SA_AX, SB_AX, 1'b0, 1'b0, 1'b1, 1'b0, D_M00},
        '{SA_AW, SB_AW, 1'b0, 1'b0, 1'b0, 1'b0, D_M00},
        '{SA_AY, SB_AY, 1'b1, 1'b0, 1'b0, 1'b0, D_M00},
        '{SA_AZ, SB_AZ, 1'b1, 1'b0, 1'b0, 1'b1, D_M00},
        '{SA_AX, SB_AY, 1'b0, 1'b1, 1'b1, 1'b0, D_M01},
        '{SA_AW, SB_AZ, 1'b1, 1'b1, 1'b0, 1'b1, D_M01},
        '{SA_AX, SB_AZ, 1'b0, 1'b1, 1'b1, 1'b0, D_M02},
        '{SA_AW, SB_AY, 1'b0, 1'b1, 1'b0, 1'b1, D_M02},
        '{SA_AW, SB_AZ, 1'b0, 1'b1, 1'b1, 1'b0, D_M10},
        '{SA_AX, SB_AY, 1'b0, 1'b1, 1'b0, 1'b1, D_M10},
        '{SA_AW, SB_AW, 1'b0, 1'b0, 1'b1, 1'b0, D_M11},
        '{SA_AX, SB_AX, 1'b1, 1'b0, 1'b0, 1'b0, D_M11},
        '{SA_AY, SB_AY, 1'b0, 1'b0, 1'b0, 1'b0, D_M11},
        '{SA_AZ, SB_AZ, 1'b1, 1'b0, 1'b0, 1'b1, D_M11},
        '{SA_AY, SB_AZ, 1'b0, 1'b1, 1'b1, 1'b0, D_M12},
        '{SA_AW, SB_AX, 1'b1, 1'b1, 1'b0, 1'b1, D_M12},
        '{SA_AX, SB_AZ, 1'b0, 1'b1, 1'b1, 1'b0, D_M20},
        '{SA_AW, SB_AY, 1'b1, 1'b1, 1'b0, 1'b1, D_M20},
        '{SA_AW, SB_AX, 1'b0, 1'b1, 1'b1, 1'b0, D_M21},
        '{SA_AY, SB_AZ, 1'b0, 1'b1, 1'b0, 1'b1, D_M21},
        '{SA_AW, SB_AW, 1'b0, 1'b0, 1'b1, 1'b0, D_M22},
        '{SA_AX, SB_AX, 1'b1, 1'b0, 1'b0, 1'b0, D_M22},
        '{SA_AY, SB_AY, 1'b1, 1'b0, 1'b0, 1'b0, D_M22},
        '{SA_AZ, SB_AZ, 1'b0, 1'b0, 1'b0, 1'b1, D_M22},
        '{SA_VX, SB_M00, 1'b0, 1'b0, 1'b1, 1'b0, D_PX},
        '{SA_VY, SB_M01, 1'b0, 1'b0, 1'b0, 1'b0, D_PX},
        '{SA_VZ, SB_M02, 1'b0, 1'b0, 1'b0, 1'b1, D_PX},
        '{SA_VX, SB_M10, 1'b0, 1'b0, 1'b1, 1'b0, D_PY},
        '{SA_VY, SB_M11, 1'b0, 1'b0, 1'b0, 1'b0, D_PY},
        '{SA_VZ, SB_M12, 1'b0, 1'b0, 1'b0, 1'b1, D_PY},
        '{SA_VX, SB_M20, 1'b0, 1'b0, 1'b1, 1'b0, D_PZ},
        '{SA_VY, SB_M21, 1'b0, 1'b0, 1'b0, 1'b0, D_PZ},
        '{SA_VZ, SB_M22, 1'b0, 1'b0, 1'b0, 1'b1, D_PZ}
    };

    // Controller to datapath commands.
    typedef struct packed {
        logic  flag_clear;
        logic  flag_we;
        logic  flag_val;
        logic  pose_we;
        logic  pose_from_result;
        logic  rd_en;
        logic  miss_we;
        logic  miss_val;
        logic  step_valid;
        step_t step;
        logic  load_out;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        op_t  op;
        logic c_ok;
        logic p_ok;
        logic parent_present;
        logic clr_last;
        logic out_busy;
    } sts_t;

endpackage

/* rtl/apr_ctrl.sv */
module apr_ctrl
    import apr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_RUN   = 8'b0001_0000,
        S_WB    = 8'b0010_0000,
        S_OUT   = 8'b0100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    step_t  step_reg;
    step_t  step_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.flag_clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (sts.op)
                    OP_STORE:
                    begin
                        cmd.pose_we  = sts.c_ok;
                        cmd.flag_we  = sts.c_ok;
                        cmd.flag_val = 1'b1;
                    end
                    OP_REMOVE:
                    begin
                        cmd.flag_we = sts.c_ok;
                    end
                    OP_RESOLVE:
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_CHECK;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CHECK:
            begin
                cmd.miss_we = 1'b1;
                if (!sts.p_ok || !sts.parent_present)
                begin
                    cmd.flag_we  = sts.c_ok;
                    cmd.miss_val = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step_valid = (step_reg < step_t'(NUM_UOPS));
                step_next      = step_reg + step_t'(1);
                if (step_reg == step_t'(STEP_END))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.pose_we          = sts.c_ok;
                cmd.pose_from_result = 1'b1;
                cmd.flag_we          = sts.c_ok;
                cmd.flag_val         = 1'b1;
                state_next           = S_OUT;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (step_reg <= step_t'(STEP_END)))
        else $error("step counter ran past the end of the program");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> $past(state_reg == S_RUN))
        else $error("write-back reached without running the program");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("output register overwritten while a transfer is pending");
`endif

endmodule

/* rtl/apr_datapath.sv */
module apr_datapath
    import apr_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [183:0]   s_tdata,
    input  logic [1:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [159:0]   m_tdata,
    output logic           m_tuser,
    input  cmd_t           cmd,
    output sts_t           sts
);

    localparam int AW    = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int ACC_W = 61;

    // Captured input item.
    logic [1:0]         op_reg;
    logic [9:0]         cidx_reg;
    logic [9:0]         pidx_reg;
    logic signed [31:0] v_reg [3];
    logic signed [15:0] b_reg [4];

    // Entity tables.
    logic               flag_mem [MAX_ENTITIES];
    logic [159:0]       pose_mem [MAX_ENTITIES];
    logic               flag_rd_reg;
    logic [159:0]       pose_rd_reg;
    logic [AW-1:0]      clr_cnt_reg;

    // Arithmetic pipeline.
    uop_t               uop_i;
    logic signed [31:0] opa;
    logic signed [25:0] opb;
    logic signed [57:0] prod_reg;
    uop_t               u1_reg;
    uop_t               u2_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic signed [15:0] q_reg [4];
    logic signed [25:0] m_reg [9];
    logic signed [31:0] pos_reg [3];
    logic               miss_reg;

    logic               out_valid_reg;
    logic [159:0]       out_data_reg;
    logic               out_miss_reg;

    logic signed [15:0] ax, ay, az, aw;
    logic signed [31:0] pp [3];
    logic [AW-1:0]      caddr;
    logic [AW-1:0]      paddr;
    logic [AW-1:0]      faddr;
    logic [159:0]       pose_wdata;

    // Round to nearest by half-LSB add and floor shift, saturate to Q1.14.
    function automatic logic signed [15:0] rnd_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + (61'sd1 <<< 13)) >>> 14;
        if (t > 61'sd32767)
            return 16'sh7FFF;
        else if (t < -61'sd32768)
            return 16'sh8000;
        else
            return t[15:0];
    endfunction

    // Matrix entries rounded to Q20.
    function automatic logic signed [25:0] rnd_m(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + (61'sd1 <<< 7)) >>> 8;
        return t[25:0];
    endfunction

    // Rotated offset rounded to Q16.16, added to parent position, saturated.
    function automatic logic signed [31:0] rnd_p(input logic signed [ACC_W-1:0] v,
                                                 input logic signed [31:0] p);
        logic signed [ACC_W-1:0] t;
        t = ((v + (61'sd1 <<< 19)) >>> 20) + ACC_W'(p);
        if (t > 61'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (t < -61'sd2147483648)
            return 32'sh8000_0000;
        else
            return t[31:0];
    endfunction

    assign caddr = AW'(cidx_reg);
    assign paddr = AW'(pidx_reg);
    assign faddr = cmd.flag_clear ? clr_cnt_reg : caddr;

    assign ax    = pose_rd_reg[15:0];
    assign ay    = pose_rd_reg[31:16];
    assign az    = pose_rd_reg[47:32];
    assign aw    = pose_rd_reg[63:48];
    assign pp[0] = pose_rd_reg[95:64];
    assign pp[1] = pose_rd_reg[127:96];
    assign pp[2] = pose_rd_reg[159:128];

    // Status toward the controller.
    assign sts.op             = op_t'(op_reg);
    assign sts.c_ok           = (32'(cidx_reg) < MAX_ENTITIES);
    assign sts.p_ok           = (32'(pidx_reg) < MAX_ENTITIES);
    assign sts.parent_present = flag_rd_reg;
    assign sts.clr_last       = (clr_cnt_reg == AW'(MAX_ENTITIES - 1));
    assign sts.out_busy       = out_valid_reg && !m_tready;

    // Capture the item on each input transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            cidx_reg <= s_tdata[9:0];
            pidx_reg <= s_tdata[19:10];
            v_reg[0] <= s_tdata[51:20];
            v_reg[1] <= s_tdata[83:52];
            v_reg[2] <= s_tdata[115:84];
            b_reg[0] <= s_tdata[131:116];
            b_reg[1] <= s_tdata[147:132];
            b_reg[2] <= s_tdata[163:148];
            b_reg[3] <= s_tdata[179:164];
        end
    end

    // Clearing pass counter for the present flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.flag_clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // Present flag memory.
    always_ff @(posedge clk)
    begin
        if (cmd.flag_we || cmd.flag_clear)
        begin
            flag_mem[faddr] <= cmd.flag_val && !cmd.flag_clear;
        end
        if (cmd.rd_en)
        begin
            flag_rd_reg <= flag_mem[paddr];
        end
    end

    // Pose memory.
    always_comb
    begin
        if (cmd.pose_from_result)
        begin
            pose_wdata = {pos_reg[2], pos_reg[1], pos_reg[0],
                          q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
        end
        else
        begin
            pose_wdata = {v_reg[2], v_reg[1], v_reg[0],
                          b_reg[3], b_reg[2], b_reg[1], b_reg[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pose_we)
        begin
            pose_mem[caddr] <= pose_wdata;
        end
        if (cmd.rd_en)
        begin
            pose_rd_reg <= pose_mem[paddr];
        end
    end

    // Operand selection for the shared multiplier.
    assign uop_i = cmd.step_valid ? UCODE[cmd.step] : '0;

    always_comb
    begin
        case (uop_i.a)
            SA_AX:   opa = 32'(ax);
            SA_AY:   opa = 32'(ay);
            SA_AZ:   opa = 32'(az);
            SA_AW:   opa = 32'(aw);
            SA_VX:   opa = v_reg[0];
            SA_VY:   opa = v_reg[1];
            SA_VZ:   opa = v_reg[2];
            default: opa = '0;
        endcase
        case (uop_i.b)
            SB_BX:   opb = 26'(b_reg[0]);
            SB_BY:   opb = 26'(b_reg[1]);
            SB_BZ:   opb = 26'(b_reg[2]);
            SB_BW:   opb = 26'(b_reg[3]);
            SB_AX:   opb = 26'(ax);
            SB_AY:   opb = 26'(ay);
            SB_AZ:   opb = 26'(az);
            SB_AW:   opb = 26'(aw);
            SB_M00:  opb = m_reg[0];
            SB_M01:  opb = m_reg[1];
            SB_M02:  opb = m_reg[2];
            SB_M10:  opb = m_reg[3];
            SB_M11:  opb = m_reg[4];
            SB_M12:  opb = m_reg[5];
            SB_M20:  opb = m_reg[6];
            SB_M21:  opb = m_reg[7];
            SB_M22:  opb = m_reg[8];
            default: opb = '0;
        endcase
    end

    // Multiply stage.
    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        u1_reg   <= uop_i;
        u2_reg   <= u1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step_valid;
            v2_reg <= v1_reg;
        end
    end

    // Accumulate stage.
    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (u1_reg.dbl)
        begin
            term = term <<< 1;
        end
        if (u1_reg.neg)
        begin
            term = -term;
        end
        acc_next = (u1_reg.first ? '0 : acc_reg) + term;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Write-back of finished groups.
    always_ff @(posedge clk)
    begin
        if (v2_reg && u2_reg.last)
        begin
            case (u2_reg.dst)
                D_QX:    q_reg[0]   <= rnd_q(acc_reg);
                D_QY:    q_reg[1]   <= rnd_q(acc_reg);
                D_QZ:    q_reg[2]   <= rnd_q(acc_reg);
                D_QW:    q_reg[3]   <= rnd_q(acc_reg);
                D_M00:   m_reg[0]   <= rnd_m(acc_reg);
                D_M01:   m_reg[1]   <= rnd_m(acc_reg);
                D_M02:   m_reg[2]   <= rnd_m(acc_reg);
                D_M10:   m_reg[3]   <= rnd_m(acc_reg);
                D_M11:   m_reg[4]   <= rnd_m(acc_reg);
                D_M12:   m_reg[5]   <= rnd_m(acc_reg);
                D_M20:   m_reg[6]   <= rnd_m(acc_reg);
                D_M21:   m_reg[7]   <= rnd_m(acc_reg);
                D_M22:   m_reg[8]   <= rnd_m(acc_reg);
                D_PX:    pos_reg[0] <= rnd_p(acc_reg, pp[0]);
                D_PY:    pos_reg[1] <= rnd_p(acc_reg, pp[1]);
                D_PZ:    pos_reg[2] <= rnd_p(acc_reg, pp[2]);
                default: pos_reg[0] <= pos_reg[0];
            endcase
        end
    end

    // Missing-parent mark and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.miss_we)
        begin
            miss_reg <= cmd.miss_val;
        end
        if (cmd.load_out)
        begin
            out_miss_reg <= miss_reg;
            if (miss_reg)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg <= {q_reg[3], q_reg[2], q_reg[1], q_reg[0],
                                 pos_reg[2], pos_reg[1], pos_reg[0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_miss_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_miss_reg) |-> (out_data_reg == '0))
        else $error("missing-parent result carries a nonzero pose");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flag_clear |-> !(cmd.pose_we || cmd.rd_en || cmd.step_valid))
        else $error("table access during the clearing pass");
`endif

endmodule

/* rtl/attached_pose_resolver.sv */
// Store and remove items update the table in the cycle after the transfer; unknown items are dropped.
// A resolve reads the tables, then runs 49 multiply-accumulate steps through one shared 32x26
// multiplier, then drains the pipeline and writes back.
// A resolve against an absent or out-of-range parent skips the arithmetic and returns a zero pose.
// One item is in work at a time; a result waits in the output register, stalling the next result.
// rst_n is asynchronous and active low; a clearing pass over all MAX_ENTITIES entries zeroes the flags.
module attached_pose_resolver
    import apr_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entity_index, parent_index, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
    input  logic [183:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_quat_x, out_quat_y, out_quat_z, out_quat_w
    output logic [159:0] m_tdata,
    // parent_missing
    output logic         m_tuser
);

    cmd_t cmd;
    sts_t sts;

    // Sequencing control.
    apr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Tables, arithmetic and output register.
    apr_datapath #(
        .MAX_ENTITIES (MAX_ENTITIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
